// ===== rtl/olid_pkg.sv =====
// Shared types and constants of the ordered list block.
package olid_pkg;

   localparam int CmdW   = 2;
   localparam int PosW   = 5;
   localparam int IdW    = 16;
   localparam int DataW  = 32;
   localparam int CountW = 5;

   // Command codes carried on the request channel.
   typedef enum logic [CmdW-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_PURGE  = 2'd3
   } cmd_type;

   // What every cell of the row does in the current cycle.
   typedef enum logic [2:0] {
      MODE_HOLD   = 3'd0,
      MODE_INSERT = 3'd1,
      MODE_DELETE = 3'd2,
      MODE_MATCH  = 3'd3,
      MODE_PURGE  = 3'd4
   } mode_type;

   // Control broadcast from the sequencer to all cells.
   typedef struct packed {
      mode_type         mode;
      logic [IdW-1:0]   key_id;
      logic             entry_stable;
   } cell_ctl_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

endpackage

// ===== rtl/olid_if.sv =====
// Request and response channel interfaces of the ordered list block.
interface olid_req_if import olid_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CmdW-1:0]   cmd;
   logic [PosW-1:0]   position;
   logic [IdW-1:0]    key_id;
   logic [DataW-1:0]  entry_data;
   logic              entry_stable;

   modport source (output valid, cmd, position, key_id, entry_data, entry_stable,
                   input ready);
   modport sink   (input valid, cmd, position, key_id, entry_data, entry_stable,
                   output ready);
endinterface

interface olid_rsp_if import olid_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     status;
   logic signed [PosW-1:0]   found_pos;
   logic [IdW-1:0]           removed_id;
   logic [DataW-1:0]         removed_data;
   logic                     removed_stable;
   logic [CountW-1:0]        entry_count;

   modport source (output valid, status, found_pos, removed_id, removed_data,
                   removed_stable, entry_count, input ready);
   modport sink   (input valid, status, found_pos, removed_id, removed_data,
                   removed_stable, entry_count, output ready);
endinterface

// ===== rtl/olid_cell.sv =====
// One slot of the list: holds an entry and shifts it to or from its neighbours.
module olid_cell import olid_pkg::*; #(
   parameter int INDEX  = 0,
   parameter int CMP_W  = 5,
   parameter int DATA_W = 32
) (
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  logic [DATA_W-1:0]   new_data,
   input  logic [CMP_W-1:0]    pos,
   input  logic [CMP_W-1:0]    count,
   input  logic [IdW-1:0]      prev_id,
   input  logic [DATA_W-1:0]   prev_data,
   input  logic                prev_stable,
   input  logic [IdW-1:0]      next_id,
   input  logic [DATA_W-1:0]   next_data,
   input  logic                next_stable,
   input  logic                carry_in,
   output logic                carry_out,
   output logic                first,
   output logic [IdW-1:0]      id_out,
   output logic [DATA_W-1:0]   data_out,
   output logic                stable_out
);

   localparam logic [CMP_W-1:0] MyIndex = CMP_W'(INDEX);

   logic [IdW-1:0]    id_ff, id_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              stable_ff, stable_in;
   logic              occupied, at_pos, above_pos, flag;

   assign occupied  = MyIndex < count;
   assign at_pos    = MyIndex == pos;
   assign above_pos = MyIndex > pos;

   // The flag marks the cell that a delete removes, an id match or an unstable entry;
   // the carry tells the cells further up that a flag has been seen below them.
   always_comb begin
      case (ctl.mode)
         MODE_DELETE: flag = at_pos;
         MODE_MATCH:  flag = occupied && (id_ff == ctl.key_id);
         MODE_PURGE:  flag = occupied && !stable_ff;
         default:     flag = 1'b0;
      endcase
   end

   assign carry_out = carry_in | flag;
   assign first     = flag & ~carry_in;

   always_comb begin
      id_in     = id_ff;
      data_in   = data_ff;
      stable_in = stable_ff;
      case (ctl.mode)
         MODE_INSERT: begin
            if (at_pos) begin
               id_in     = ctl.key_id;
               data_in   = new_data;
               stable_in = ctl.entry_stable;
            end else if (above_pos) begin
               id_in     = prev_id;
               data_in   = prev_data;
               stable_in = prev_stable;
            end
         end
         MODE_DELETE, MODE_PURGE: begin
            if (carry_out) begin
               id_in     = next_id;
               data_in   = next_data;
               stable_in = next_stable;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      data_ff   <= data_in;
      stable_ff <= stable_in;
   end

   assign id_out     = id_ff;
   assign data_out   = data_ff;
   assign stable_out = stable_ff;

endmodule

// ===== rtl/ordered_list_insert_delete_search.sv =====
// Top level of the ordered list block: a row of entry cells and its command sequencer.
//
// The block keeps an ordered list of up to LIST_DEPTH entries, each an id, a payload
// and a stable flag, in a row of identical cells; every cell holds one slot and can
// take the entry of its lower or upper neighbour. One transaction is handled at a
// time. After a request transaction is accepted, insert, delete and find pass through
// the cell row in the execute state, and the response transaction is offered in the
// following cycle; a new request is accepted in the same cycle as that response is
// taken. Removing the unstable entries shifts the row down by one entry per cycle
// until no unstable entry is left; the one shift step per cycle of the cell row is
// what sets this rate. An insert at a position past the count or into a full list,
// and a delete at or past the count, are rejected with status 1 and leave the list
// unchanged. found_pos is all ones unless a find matches, and the removed fields are
// zero unless a delete succeeds. The payload is kept at PAYLOAD_BITS bits, at most
// 32; wider upper bits of a request are dropped.
module ordered_list_insert_delete_search import olid_pkg::*; #(
   parameter int LIST_DEPTH   = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input logic         clock,
   input logic         reset,
   olid_req_if.sink    req_bus,
   olid_rsp_if.source  rsp_bus
);

   localparam int StoreW = (PAYLOAD_BITS < DataW) ? PAYLOAD_BITS : DataW;
   localparam int CntW   = $clog2(LIST_DEPTH + 1);
   // Width in which positions and counts are compared inside the row.
   localparam int CmpW   = (CntW > PosW) ? CntW : PosW;

   // Sequencer state and the accepted command.
   state_type         state_ff, state_in;
   logic [CntW-1:0]   count_ff, count_in;
   cmd_type           cmd_ff;
   logic [PosW-1:0]   pos_ff;
   logic [IdW-1:0]    key_ff;
   logic [StoreW-1:0] data_ff;
   logic              stable_ff;

   // Response register.
   logic              status_ff, status_in;
   logic [PosW-1:0]   found_ff, found_in;
   logic [IdW-1:0]    rem_id_ff, rem_id_in;
   logic [StoreW-1:0] rem_data_ff, rem_data_in;
   logic              rem_stable_ff, rem_stable_in;

   logic              req_acc, rsp_acc;
   logic              reject_ins, reject_del;
   logic [CmpW-1:0]   pos_cmp, count_cmp;
   cell_ctl_type      ctl;

   // Cell row connections.
   logic [IdW-1:0]    cell_id     [LIST_DEPTH];
   logic [StoreW-1:0] cell_data   [LIST_DEPTH];
   logic              cell_stable [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] cell_first;
   logic [LIST_DEPTH:0]   carry;

   // Values picked out of the row by the single cell whose first flag is set.
   logic [IdW-1:0]    pick_id;
   logic [StoreW-1:0] pick_data;
   logic              pick_stable;
   logic [PosW-1:0]   pick_index;
   logic              any_flag;

   assign req_acc = req_bus.valid && req_bus.ready;
   assign rsp_acc = rsp_bus.valid && rsp_bus.ready;

   // A new request is taken when the block is idle, or as the pending response leaves.
   // Nothing is taken while reset is held.
   assign req_bus.ready = !reset &&
                          ((state_ff == ST_IDLE) || ((state_ff == ST_RESP) && rsp_bus.ready));

   assign pos_cmp    = CmpW'(pos_ff);
   assign count_cmp  = CmpW'(count_ff);
   assign reject_ins = (count_ff == CntW'(LIST_DEPTH)) || (pos_cmp > count_cmp);
   assign reject_del = pos_cmp >= count_cmp;

   assign carry[0] = 1'b0;
   assign any_flag = carry[LIST_DEPTH];

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic [IdW-1:0]    prev_id, next_id;
      logic [StoreW-1:0] prev_data, next_data;
      logic              prev_stable, next_stable;

      // The ends of the row see their own entry in place of a missing neighbour.
      if (g == 0) begin : g_low
         assign prev_id     = cell_id[g];
         assign prev_data   = cell_data[g];
         assign prev_stable = cell_stable[g];
      end else begin : g_low
         assign prev_id     = cell_id[g-1];
         assign prev_data   = cell_data[g-1];
         assign prev_stable = cell_stable[g-1];
      end
      if (g == LIST_DEPTH - 1) begin : g_high
         assign next_id     = cell_id[g];
         assign next_data   = cell_data[g];
         assign next_stable = cell_stable[g];
      end else begin : g_high
         assign next_id     = cell_id[g+1];
         assign next_data   = cell_data[g+1];
         assign next_stable = cell_stable[g+1];
      end

      olid_cell #(
         .INDEX  (g),
         .CMP_W  (CmpW),
         .DATA_W (StoreW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .new_data    (data_ff),
         .pos         (pos_cmp),
         .count       (count_cmp),
         .prev_id     (prev_id),
         .prev_data   (prev_data),
         .prev_stable (prev_stable),
         .next_id     (next_id),
         .next_data   (next_data),
         .next_stable (next_stable),
         .carry_in    (carry[g]),
         .carry_out   (carry[g+1]),
         .first       (cell_first[g]),
         .id_out      (cell_id[g]),
         .data_out    (cell_data[g]),
         .stable_out  (cell_stable[g])
      );
   end

   // At most one cell raises its first flag, so an OR over the row selects its entry.
   always_comb begin
      pick_id     = '0;
      pick_data   = '0;
      pick_stable = 1'b0;
      pick_index  = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (cell_first[i]) begin
            pick_id     = pick_id | cell_id[i];
            pick_data   = pick_data | cell_data[i];
            pick_stable = pick_stable | cell_stable[i];
            pick_index  = pick_index | PosW'(i);
         end
      end
   end

   // Row control. The row mode is driven only in the execute state, and only for a
   // command that is not rejected; it depends on registered values alone.
   always_comb begin
      ctl.mode         = MODE_HOLD;
      ctl.key_id       = key_ff;
      ctl.entry_stable = stable_ff;
      if (state_ff == ST_EXEC) begin
         case (cmd_ff)
            CMD_INSERT: begin
               if (!reject_ins) begin
                  ctl.mode = MODE_INSERT;
               end
            end
            CMD_DELETE: begin
               if (!reject_del) begin
                  ctl.mode = MODE_DELETE;
               end
            end
            CMD_FIND: begin
               ctl.mode = MODE_MATCH;
            end
            CMD_PURGE: begin
               ctl.mode = MODE_PURGE;
            end
            default: begin
               ctl.mode = MODE_HOLD;
            end
         endcase
      end
   end

   // Command sequencer. The response register is loaded on the cycle in which a
   // command completes.
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      status_in        = status_ff;
      found_in         = found_ff;
      rem_id_in        = rem_id_ff;
      rem_data_in      = rem_data_ff;
      rem_stable_in    = rem_stable_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in     = 1'b0;
            found_in      = '1;
            rem_id_in     = '0;
            rem_data_in   = '0;
            rem_stable_in = 1'b0;
            state_in      = ST_RESP;
            case (cmd_ff)
               CMD_INSERT: begin
                  status_in = reject_ins;
                  if (!reject_ins) begin
                     count_in = count_ff + CntW'(1);
                  end
               end
               CMD_DELETE: begin
                  status_in = reject_del;
                  if (!reject_del) begin
                     count_in      = count_ff - CntW'(1);
                     rem_id_in     = pick_id;
                     rem_data_in   = pick_data;
                     rem_stable_in = pick_stable;
                  end
               end
               CMD_FIND: begin
                  if (any_flag) begin
                     found_in = pick_index;
                  end
               end
               CMD_PURGE: begin
                  // Drop the lowest unstable entry and look again next cycle.
                  if (any_flag) begin
                     count_in = count_ff - CntW'(1);
                     state_in = ST_EXEC;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_RESP: begin
            if (rsp_acc) begin
               state_in = req_acc ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Command and response payload registers.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff    <= cmd_type'(req_bus.cmd);
         pos_ff    <= req_bus.position;
         key_ff    <= req_bus.key_id;
         data_ff   <= req_bus.entry_data[StoreW-1:0];
         stable_ff <= req_bus.entry_stable;
      end
      status_ff     <= status_in;
      found_ff      <= found_in;
      rem_id_ff     <= rem_id_in;
      rem_data_ff   <= rem_data_in;
      rem_stable_ff <= rem_stable_in;
   end

   assign rsp_bus.valid          = state_ff == ST_RESP;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.found_pos      = $signed(found_ff);
   assign rsp_bus.removed_id     = rem_id_ff;
   assign rsp_bus.removed_data   = DataW'(rem_data_ff);
   assign rsp_bus.removed_stable = rem_stable_ff;
   assign rsp_bus.entry_count    = CountW'(count_ff);

   // The entry count never runs past the depth of the row.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(LIST_DEPTH))
      else $error("entry count exceeds the list depth");

   // Only an insert can make the list grow.
   a_grow_only_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && (cmd_ff != CMD_INSERT) |=> count_ff <= $past(count_ff))
      else $error("list grew on a command other than insert");

   // A rejected command reports no match and no removed entry.
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status |->
         (found_ff == '1) && (rem_id_ff == '0) && (rem_data_ff == '0) && !rem_stable_ff)
      else $error("rejected transaction carries result fields");

endmodule
